### sv/psd_pkg.sv
// Shared types, codes and constants of the pixel detector stream decoder.
package psd_pkg;

    localparam int WORD_W    = 48;
    localparam int PAYLOAD_W = 44;
    localparam int TIME_W    = 46;
    localparam int TOA_W     = 14;
    localparam int CFG_W     = 32;

    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // Word headers.
    localparam logic [3:0] HDR_PIXEL     = 4'h4;
    localparam logic [3:0] HDR_OFFSET    = 4'h5;
    localparam logic [3:0] HDR_START     = 4'h7;
    localparam logic [3:0] HDR_START_LO  = 4'h8;
    localparam logic [3:0] HDR_START_HI  = 4'h9;
    localparam logic [3:0] HDR_END_LO    = 4'hA;
    localparam logic [3:0] HDR_END_HI    = 4'hB;
    localparam logic [3:0] HDR_FINISH    = 4'hC;
    localparam logic [3:0] HDR_LOST      = 4'hD;
    localparam logic [3:0] HDR_ABORT     = 4'hE;

    // Pixel formats.
    localparam logic [2:0] FMT_FAST_TOA   = 3'd2;
    localparam logic [2:0] FMT_TOA        = 3'd3;
    localparam logic [2:0] FMT_FAST_EVENT = 3'd4;
    localparam logic [2:0] FMT_EVENT      = 3'd5;

    // Configuration register indexes.
    localparam logic CFG_PIXEL_FORMAT     = 1'b0;
    localparam logic CFG_REQUESTED_FRAMES = 1'b1;

    typedef enum logic [3:0] {
        OP_PIXEL,
        OP_OFFSET,
        OP_START,
        OP_START_LO,
        OP_START_HI,
        OP_END_LO,
        OP_END_HI,
        OP_FINISH,
        OP_LOST,
        OP_ABORT,
        OP_DROP
    } op_t;

    typedef enum logic [2:0] {
        KIND_PIXEL     = 3'd0,
        KIND_STARTED   = 3'd1,
        KIND_ENDED     = 3'd2,
        KIND_ALL_DONE  = 3'd3,
        KIND_ABORTED   = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        RUN_RUNNING   = 2'd0,
        RUN_SUCCEEDED = 2'd1,
        RUN_ABORTED   = 2'd2
    } run_status_t;

    // One classified word as it travels from the front end to the back end.
    typedef struct packed {
        op_t                    op;
        logic                   add_offset;
        logic                   keep_low;
        logic                   keep_mid;
        logic [PAYLOAD_W-1:0]   payload;
    } item_t;

    typedef struct packed {
        kind_t          kind;
        logic [31:0]    frame_index;
        logic [7:0]     coord_x;
        logic [7:0]     coord_y;
        logic [TIME_W-1:0] time_or_integral;
        logic [3:0]     low_nibble;
        logic [9:0]     mid_field;
        logic [47:0]    frame_start;
        logic [47:0]    frame_end;
        logic [31:0]    rx_pixels;
        logic [43:0]    tx_pixels;
        logic [47:0]    lost_total;
    } result_t;

    typedef struct packed {
        run_status_t    run_status;
        logic [31:0]    dropped_words;
    } status_t;

endpackage

### sv/psd_front.sv
// Front end: takes measurement words and classifies them into queue entries.
module psd_front (
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [psd_pkg::WORD_W-1:0]     s_word,
    input  logic [2:0]                     pixel_format,
    output logic                           push_valid,
    input  logic                           push_ready,
    output psd_pkg::item_t                 push_item
);
    import psd_pkg::*;

    logic [3:0] header;
    logic       format_ok;

    assign header    = s_word[WORD_W-1 -: 4];
    assign format_ok = (pixel_format <= FMT_EVENT);

    assign s_ready    = push_ready;
    assign push_valid = s_valid;

    always_comb begin
        push_item.payload    = s_word[PAYLOAD_W-1:0];
        // Event formats carry integral tot in place of a time of arrival.
        push_item.add_offset = (pixel_format < FMT_FAST_EVENT);
        push_item.keep_low   = (pixel_format != FMT_EVENT);
        push_item.keep_mid   = (pixel_format != FMT_FAST_TOA) && (pixel_format != FMT_TOA);
        unique case (header)
            HDR_PIXEL:    push_item.op = format_ok ? OP_PIXEL : OP_DROP;
            HDR_OFFSET:   push_item.op = OP_OFFSET;
            HDR_START:    push_item.op = OP_START;
            HDR_START_LO: push_item.op = OP_START_LO;
            HDR_START_HI: push_item.op = OP_START_HI;
            HDR_END_LO:   push_item.op = OP_END_LO;
            HDR_END_HI:   push_item.op = OP_END_HI;
            HDR_FINISH:   push_item.op = OP_FINISH;
            HDR_LOST:     push_item.op = OP_LOST;
            HDR_ABORT:    push_item.op = OP_ABORT;
            default:      push_item.op = OP_DROP;
        endcase
    end

endmodule

### sv/psd_queue.sv
// Short queue of classified words between the front end and the back end.
module psd_queue #(
    parameter int DEPTH = psd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_valid,
    output logic            push_ready,
    input  psd_pkg::item_t  push_item,
    output logic            pop_valid,
    input  logic            pop_ready,
    output psd_pkg::item_t  pop_item
);
    import psd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t              entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### sv/psd_back.sv
// Back end: applies classified words to the frame record and builds results.
module psd_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  psd_pkg::item_t      pop_item,
    input  logic [31:0]         frames_wanted,
    output logic                m_valid,
    input  logic                m_ready,
    output psd_pkg::result_t    result,
    output psd_pkg::status_t    status
);
    import psd_pkg::*;

    logic [TIME_W-1:0]  time_offset_reg, time_offset_next;
    logic [31:0]        frames_done_reg, frames_done_next;
    run_status_t        run_status_reg, run_status_next;
    logic [31:0]        dropped_reg, dropped_next;
    logic [31:0]        received_reg, received_next;
    logic [47:0]        lost_reg, lost_next;
    logic [47:0]        start_stamp_reg, start_stamp_next;
    logic [47:0]        end_stamp_reg, end_stamp_next;
    logic               out_valid_reg, out_valid_next;
    result_t            result_reg, result_next;

    logic               do_pop;
    logic               has_result;
    logic [31:0]        frames_inc;
    logic [48:0]        lost_sum;
    logic [TOA_W-1:0]   toa;
    logic [PAYLOAD_W-1:0] pay;

    // A word leaves the queue whenever the result register is free or being drained.
    assign pop_ready = !out_valid_reg || m_ready;
    assign do_pop    = pop_valid && pop_ready;
    assign pay       = pop_item.payload;
    assign toa       = pay[27:14];
    assign frames_inc = (frames_done_reg == '1) ? frames_done_reg : frames_done_reg + 1'b1;
    assign lost_sum  = {1'b0, lost_reg} + {5'b0, pay};

    always_comb begin
        time_offset_next = time_offset_reg;
        frames_done_next = frames_done_reg;
        run_status_next  = run_status_reg;
        dropped_next     = dropped_reg;
        received_next    = received_reg;
        lost_next        = lost_reg;
        start_stamp_next = start_stamp_reg;
        end_stamp_next   = end_stamp_reg;
        has_result       = 1'b0;
        result_next      = '0;
        result_next.frame_index = frames_done_reg;

        unique case (pop_item.op)
            OP_PIXEL: begin
                has_result               = 1'b1;
                result_next.kind         = KIND_PIXEL;
                result_next.coord_x      = pay[35:28];
                result_next.coord_y      = pay[43:36];
                result_next.time_or_integral = pop_item.add_offset
                                             ? time_offset_reg + TIME_W'(toa)
                                             : TIME_W'(toa);
                result_next.low_nibble   = pop_item.keep_low ? pay[3:0] : 4'h0;
                result_next.mid_field    = pop_item.keep_mid ? pay[13:4] : 10'h0;
                received_next = (received_reg == '1) ? received_reg : received_reg + 1'b1;
            end
            OP_OFFSET: begin
                time_offset_next = {pay[31:0], {TOA_W{1'b0}}};
            end
            OP_START: begin
                has_result       = 1'b1;
                result_next.kind = KIND_STARTED;
                received_next    = '0;
                lost_next        = '0;
                start_stamp_next = '0;
                end_stamp_next   = '0;
            end
            OP_START_LO: start_stamp_next = {start_stamp_reg[47:32], pay[31:0]};
            OP_START_HI: start_stamp_next = {pay[15:0], start_stamp_reg[31:0]};
            OP_END_LO:   end_stamp_next   = {end_stamp_reg[47:32], pay[31:0]};
            OP_END_HI:   end_stamp_next   = {pay[15:0], end_stamp_reg[31:0]};
            OP_FINISH: begin
                has_result                  = 1'b1;
                result_next.frame_start     = start_stamp_reg;
                result_next.frame_end       = end_stamp_reg;
                result_next.rx_pixels       = received_reg;
                result_next.lost_total      = lost_reg;
                result_next.tx_pixels       = pay;
                frames_done_next            = frames_inc;
                if (frames_inc == frames_wanted) begin
                    run_status_next  = RUN_SUCCEEDED;
                    result_next.kind = KIND_ALL_DONE;
                end else begin
                    result_next.kind = KIND_ENDED;
                end
            end
            OP_LOST: begin
                lost_next = lost_sum[48] ? '1 : lost_sum[47:0];
            end
            OP_ABORT: begin
                has_result                  = 1'b1;
                run_status_next             = RUN_ABORTED;
                result_next.kind            = KIND_ABORTED;
                result_next.frame_start     = start_stamp_reg;
                result_next.frame_end       = end_stamp_reg;
                result_next.rx_pixels       = received_reg;
                result_next.lost_total      = lost_reg;
            end
            OP_DROP: begin
                dropped_next = (dropped_reg == '1) ? dropped_reg : dropped_reg + 1'b1;
            end
            default: begin
                dropped_next = dropped_reg;
            end
        endcase
    end

    always_comb begin
        if (do_pop) begin
            out_valid_next = has_result;
        end else begin
            out_valid_next = out_valid_reg && !m_ready;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_offset_reg <= '0;
            frames_done_reg <= '0;
            run_status_reg  <= RUN_RUNNING;
            dropped_reg     <= '0;
            received_reg    <= '0;
            lost_reg        <= '0;
            start_stamp_reg <= '0;
            end_stamp_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (do_pop) begin
                time_offset_reg <= time_offset_next;
                frames_done_reg <= frames_done_next;
                run_status_reg  <= run_status_next;
                dropped_reg     <= dropped_next;
                received_reg    <= received_next;
                lost_reg        <= lost_next;
                start_stamp_reg <= start_stamp_next;
                end_stamp_reg   <= end_stamp_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_pop && has_result) begin
            result_reg <= result_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign result  = result_reg;
    assign status.run_status    = run_status_reg;
    assign status.dropped_words = dropped_reg;

endmodule

### sv/pixel_detector_stream_decoder_unit.sv
// Top level of the pixel detector stream decoder: front end, queue and back end.
//
// Usage: one 48-bit measurement word is offered per request on s_word with
// s_valid/s_ready. The top nibble selects the action: pixel words are unpacked
// under the configured pixel format, control words start, stamp, count lost
// pixels in, end or abort a frame. Pixel words under pixel formats 0 to 5, frame
// start, frame end and abort words each give one result request on the m_ channel;
// all other words give none. The user must write the registers through
// cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it. A word
// passes through the queue, then the back end loads the result register. Throughput:
// one word per cycle while the result register is free or drained, set by the
// single back-end step that updates the frame record and loads the result register
// in the same cycle. Stalls: while m_ready is low the result register holds its
// request; words still flow in until QUEUE_DEPTH entries wait, then s_ready drops.
// Reset (aresetn low, synchronous): queue emptied, result register invalid,
// frame record, counters and time offset cleared, run status running,
// pixel format 0 and requested frame count 1.
module pixel_detector_stream_decoder_unit #(
    parameter int QUEUE_DEPTH = psd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [47:0]     s_word,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [2:0]      m_kind,
    output logic [31:0]     m_frame_index,
    output logic [7:0]      m_coord_x,
    output logic [7:0]      m_coord_y,
    output logic [45:0]     m_time_or_integral,
    output logic [3:0]      m_low_nibble,
    output logic [9:0]      m_mid_field,
    output logic [47:0]     m_start_time,
    output logic [47:0]     m_end_time,
    output logic [31:0]     m_received_pixels,
    output logic [43:0]     m_sent_pixels,
    output logic [47:0]     m_lost_pixels,
    input  logic            cfg_we,
    input  logic            cfg_index,
    input  logic [31:0]     cfg_data
);
    import psd_pkg::*;

    logic [2:0]     pixel_format_reg;
    logic [31:0]    frame_goal_reg;

    logic           push_valid, push_ready;
    item_t          push_item;
    logic           pop_valid, pop_ready;
    item_t          pop_item;
    result_t        result;
    status_t        status;

    // Configuration registers. The front end reads the pixel format when it
    // classifies a word; the user must write only while idle; not enforced here.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_format_reg <= 3'd0;
            frame_goal_reg   <= 32'd1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_PIXEL_FORMAT:     pixel_format_reg <= cfg_data[2:0];
                CFG_REQUESTED_FRAMES: frame_goal_reg   <= cfg_data;
                default:              pixel_format_reg <= pixel_format_reg;
            endcase
        end
    end

    psd_front u_front (
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_word       (s_word),
        .pixel_format (pixel_format_reg),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_item    (push_item)
    );

    psd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    psd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_item      (pop_item),
        .frames_wanted (frame_goal_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .result        (result),
        .status        (status)
    );

    assign m_kind             = result.kind;
    assign m_frame_index      = result.frame_index;
    assign m_coord_x          = result.coord_x;
    assign m_coord_y          = result.coord_y;
    assign m_time_or_integral = result.time_or_integral;
    assign m_low_nibble       = result.low_nibble;
    assign m_mid_field        = result.mid_field;
    assign m_start_time       = result.frame_start;
    assign m_end_time         = result.frame_end;
    assign m_received_pixels  = result.rx_pixels;
    assign m_sent_pixels      = result.tx_pixels;
    assign m_lost_pixels      = result.lost_total;

    // No result request may appear in the cycle right after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // While an abort result waits, the recorded run status must already be aborted.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == KIND_ABORTED) |-> status.run_status == RUN_ABORTED)
        else $error("abort result without aborted run status");

    // A completion result implies the run status has been set to succeeded.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == KIND_ALL_DONE) |-> status.run_status == RUN_SUCCEEDED)
        else $error("completion result without succeeded run status");

    // The dropped word counter never decreases outside reset.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> status.dropped_words >= $past(status.dropped_words))
        else $error("dropped word counter went backwards");

endmodule
